// File: hdl/dmb_pkg.sv
// ----------------------------------------------------------------------------
// dmb_pkg
// Shared types, codes and helpers for the differential drive mixer.
// ----------------------------------------------------------------------------
package dmb_pkg;

    // drive command codes carried in the request tuser
    typedef enum logic [2:0] {
        OP_FORWARD  = 3'd0,
        OP_BACKWARD = 3'd1,
        OP_LEFT     = 3'd2,
        OP_RIGHT    = 3'd3,
        OP_STOP     = 3'd4,
        OP_SET_FWD  = 3'd5,
        OP_SET_TURN = 3'd6,
        OP_TICK     = 3'd7
    } opcode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_BOOST_SPEED       = 3'd0,
        REG_CRUISE_SPEED      = 3'd1,
        REG_BOOST_TURN_SPEED  = 3'd2,
        REG_CRUISE_TURN_SPEED = 3'd3,
        REG_BOOST_TICKS       = 3'd4
    } cfg_index_t;

    localparam logic signed [8:0] CMD_MAX    = 9'sd255;
    localparam logic signed [8:0] CMD_MIN    = -9'sd255;
    localparam logic signed [8:0] SPIN_SPEED = 9'sd128;
    localparam logic [16:0]       TICK_SAT   = 17'd65536;

    // configuration register file contents
    typedef struct packed {
        logic [7:0]  boost_speed;
        logic [7:0]  cruise_speed;
        logic [7:0]  boost_turn_speed;
        logic [7:0]  cruise_turn_speed;
        logic [15:0] boost_ticks;
    } cfg_t;

    // mixing request from the command stage
    typedef struct packed {
        logic              stopped;
        logic              boost;
        logic signed [8:0] fwd;
        logic signed [8:0] turn;
        logic [7:0]        base;
        logic [7:0]        tspd;
    } mix_req_t;

    // floor(p / 255) for p up to 255*255, shift-add form
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

// File: hdl/dmb_cmd.sv
// ----------------------------------------------------------------------------
// dmb_cmd
// Command decode: updates forward/turn commands, boost flag and tick counter,
// and registers one mixing request per result.
// ----------------------------------------------------------------------------
module dmb_cmd (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dmb_pkg::opcode_t  opcode,
    input  logic signed [15:0] set_value,
    input  dmb_pkg::cfg_t     cfg,
    output logic              req_valid,
    input  logic              req_ready,
    output dmb_pkg::mix_req_t req
);
    import dmb_pkg::*;

    logic signed [8:0] fwd_reg, fwd_next;
    logic signed [8:0] turn_reg, turn_next;
    logic              boost_reg, boost_next;
    logic [16:0]       elapsed_reg, elapsed_next;
    logic              req_valid_reg;
    mix_req_t          req_reg, req_next;
    logic              emit;
    logic signed [8:0] clamped;
    logic              accept;

    assign in_ready  = !req_valid_reg || req_ready;
    assign accept    = in_valid && in_ready;
    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    // saturate the set value to the command range
    always_comb
    begin
        if (set_value > 16'sd255)
        begin
            clamped = CMD_MAX;
        end
        else if (set_value < -16'sd255)
        begin
            clamped = CMD_MIN;
        end
        else
        begin
            clamped = set_value[8:0];
        end
    end

    // next command state and whether a result follows
    always_comb
    begin
        fwd_next     = fwd_reg;
        turn_next    = turn_reg;
        boost_next   = boost_reg;
        elapsed_next = elapsed_reg;
        emit         = 1'b1;
        case (opcode)
            OP_FORWARD:
            begin
                fwd_next     = CMD_MAX;
                boost_next   = 1'b1;
                elapsed_next = '0;
            end
            OP_BACKWARD:
            begin
                fwd_next     = CMD_MIN;
                boost_next   = 1'b1;
                elapsed_next = '0;
            end
            OP_LEFT, OP_RIGHT:
            begin
                turn_next = (opcode == OP_LEFT) ? CMD_MIN : CMD_MAX;
                if (fwd_reg == 9'sd0)
                begin
                    fwd_next = SPIN_SPEED;
                end
                boost_next   = 1'b1;
                elapsed_next = '0;
            end
            OP_STOP:
            begin
                fwd_next   = '0;
                turn_next  = '0;
                boost_next = 1'b0;
            end
            OP_SET_FWD:
            begin
                fwd_next     = clamped;
                boost_next   = 1'b1;
                elapsed_next = '0;
            end
            OP_SET_TURN:
            begin
                turn_next = clamped;
            end
            OP_TICK:
            begin
                if (elapsed_reg < TICK_SAT)
                begin
                    elapsed_next = elapsed_reg + 17'd1;
                end
                emit = boost_reg && (elapsed_next > {1'b0, cfg.boost_ticks});
                if (emit)
                begin
                    boost_next = 1'b0;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // mixing request built from the updated state
    always_comb
    begin
        req_next.stopped = (fwd_next == 9'sd0) && (turn_next == 9'sd0);
        req_next.boost   = boost_next;
        req_next.fwd     = fwd_next;
        req_next.turn    = turn_next;
        req_next.base    = boost_next ? cfg.boost_speed : cfg.cruise_speed;
        req_next.tspd    = boost_next ? cfg.boost_turn_speed : cfg.cruise_turn_speed;
    end

    // command state and request valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= '0;
            turn_reg      <= '0;
            boost_reg     <= 1'b0;
            elapsed_reg   <= '0;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fwd_reg     <= fwd_next;
                turn_reg    <= turn_next;
                boost_reg   <= boost_next;
                elapsed_reg <= elapsed_next;
            end
            if (in_ready)
            begin
                req_valid_reg <= accept && emit;
            end
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    // a forward, backward or set-forward command always leaves boost on
    a_motion_boost: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_FORWARD || opcode == OP_BACKWARD || opcode == OP_SET_FWD)
        |=> boost_reg)
        else $error("boost not set after motion command");

    // counter never passes its saturation point
    a_elapsed_sat: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg <= TICK_SAT)
        else $error("tick counter beyond saturation");

    // a stop request always reports boost off
    a_stop_req: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_STOP) |=> req_valid_reg && req_reg.stopped && !req_reg.boost)
        else $error("stop request malformed");

endmodule

// File: hdl/dmb_mix.sv
// ----------------------------------------------------------------------------
// dmb_mix
// Mixing pipeline: scaling products, divide by 255 and left/right sum into
// the result register.
// ----------------------------------------------------------------------------
module dmb_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dmb_pkg::mix_req_t req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [9:0] left_drive,
    output logic signed [9:0] right_drive,
    output logic              stopped,
    output logic              boost_active
);
    import dmb_pkg::*;

    // product stage
    logic        prod_valid_reg;
    logic [15:0] fprod_reg, tprod_reg;
    logic        fneg_reg, tneg_reg, stop_p_reg, boost_p_reg;
    logic [8:0]  fabs, tabs;
    logic        prod_adv;

    // result stage
    logic              out_valid_reg;
    logic signed [9:0] left_reg, right_reg;
    logic              stop_reg, boost_reg;
    logic              out_adv;
    logic [7:0]        fq, tq;
    logic signed [9:0] eff, adj;

    assign out_adv   = !out_valid_reg || out_ready;
    assign prod_adv  = !prod_valid_reg || out_adv;
    assign req_ready = prod_adv;

    // command magnitudes
    assign fabs = req.fwd[8] ? 9'(-req.fwd) : req.fwd;
    assign tabs = req.turn[8] ? 9'(-req.turn) : req.turn;

    // scaled drive terms, truncated toward zero
    assign fq  = div255(fprod_reg);
    assign tq  = div255(tprod_reg);
    assign eff = fneg_reg ? -$signed({2'b00, fq}) : $signed({2'b00, fq});
    assign adj = tneg_reg ? -$signed({2'b00, tq}) : $signed({2'b00, tq});

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_adv)
            begin
                prod_valid_reg <= req_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (prod_adv && req_valid)
        begin
            fprod_reg   <= fabs[7:0] * req.base;
            tprod_reg   <= tabs[7:0] * req.tspd;
            fneg_reg    <= req.fwd[8];
            tneg_reg    <= req.turn[8];
            stop_p_reg  <= req.stopped;
            boost_p_reg <= req.boost;
        end
        if (out_adv && prod_valid_reg)
        begin
            left_reg  <= eff - adj;
            right_reg <= eff + adj;
            stop_reg  <= stop_p_reg;
            boost_reg <= boost_p_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_drive   = left_reg;
    assign right_drive  = right_reg;
    assign stopped      = stop_reg;
    assign boost_active = boost_reg;

    // a stop result carries zero drives
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && stop_reg |-> left_reg == 10'sd0 && right_reg == 10'sd0)
        else $error("stop result with nonzero drive");

    // the drives differ by twice the turn term, so their parity matches
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> left_reg[0] == right_reg[0])
        else $error("left/right parity mismatch");

    // a waiting product is not dropped while the result stage is held
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && !out_adv |=> prod_valid_reg)
        else $error("product stage lost a request");

endmodule

// File: hdl/differential_drive_mixer_boost.sv
// ----------------------------------------------------------------------------
// differential_drive_mixer_boost
// Differential drive mixer with timed boost: top level with register file.
// ----------------------------------------------------------------------------
// Takes one drive command or tick per request and returns left/right motor
// drives. One request is accepted every cycle unless the input is stalled; a
// result passes through the command register, product register and result
// register; the three stages advance independently, so a held result only stalls
// the input once both inner stages are full. Ticks that do not end boost
// produce no result. Configuration is written through cfg_we/cfg_index/
// cfg_data and takes effect on the next request.
module differential_drive_mixer_boost (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] set_value
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] left_drive, [19:10] right_drive,
                                   // [20] stopped, [21] boost_active, [23:22] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dmb_pkg::*;

    cfg_t              cfg_reg;
    logic              req_valid, req_ready;
    mix_req_t          req;
    logic signed [9:0] left_drive, right_drive;
    logic              stopped, boost_active;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boost_speed       <= 8'd255;
            cfg_reg.cruise_speed      <= 8'd160;
            cfg_reg.boost_turn_speed  <= 8'd255;
            cfg_reg.cruise_turn_speed <= 8'd128;
            cfg_reg.boost_ticks       <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOOST_SPEED:       cfg_reg.boost_speed       <= cfg_data[7:0];
                REG_CRUISE_SPEED:      cfg_reg.cruise_speed      <= cfg_data[7:0];
                REG_BOOST_TURN_SPEED:  cfg_reg.boost_turn_speed  <= cfg_data[7:0];
                REG_CRUISE_TURN_SPEED: cfg_reg.cruise_turn_speed <= cfg_data[7:0];
                REG_BOOST_TICKS:       cfg_reg.boost_ticks       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // command decode and state
    dmb_cmd u_cmd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (opcode_t'(s_tuser)),
        .set_value ($signed(s_tdata)),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // drive mixing
    dmb_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .stopped      (stopped),
        .boost_active (boost_active)
    );

    // result packing
    assign m_tdata = {2'b00, boost_active, stopped, right_drive, left_drive};

endmodule
